// File: design/bmp24_pkg.sv
// shared types and constants for the bmp24 stream parser
// no dependencies; imported by every module of the block

package bmp24_pkg;

    // default image size limits, handed to the top level parameters
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // header layout, byte positions in the file
    localparam logic [31:0] HDR_SIG0_POS   = 32'd0;
    localparam logic [31:0] HDR_SIG1_POS   = 32'd1;
    localparam logic [31:0] HDR_OFS_POS    = 32'd10;
    localparam logic [31:0] HDR_WIDTH_POS  = 32'd18;
    localparam logic [31:0] HDR_HEIGHT_POS = 32'd22;
    localparam logic [31:0] HDR_PB_POS     = 32'd26;
    localparam logic [31:0] HDR_COMP_POS   = 32'd30;
    localparam logic [31:0] HDR_FIELD_LAST = 32'd3;
    localparam logic [31:0] HDR_LAST_POS   = 32'd53;
    localparam logic [31:0] HDR_LEN        = 32'd54;

    localparam logic [7:0]  SIG_B         = 8'h42;
    localparam logic [7:0]  SIG_M         = 8'h4D;
    // one plane in the low half, 24 bits per pixel in the high half
    localparam logic [31:0] PLANES_BPP_OK = 32'h0018_0001;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef enum logic [1:0] {
        ERR_SIGNATURE = 2'd0,
        ERR_FORMAT    = 2'd1,
        ERR_OFFSET    = 2'd2,
        ERR_SIZE      = 2'd3
    } t_err_code;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_PIXELS = 2'd2,
        PH_IDLE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_req;

    typedef struct packed {
        logic       kind;
        t_err_code  error_code;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [11:0] col;
        logic [11:0] row;
        logic       last;
    } t_out_req;

    // header verdict at the last header byte
    typedef struct packed {
        logic      err;
        t_err_code code;
        logic      top_first;
        logic      zero_size;
        logic      no_skip;
    } t_hdr_chk;

endpackage

// File: design/bmp24_hdr_check.sv
// header checks evaluated at the last header byte
// depends on bmp24_pkg

module bmp24_hdr_check
    import bmp24_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic        i_sig_ok,
    input  logic [31:0] i_offset,
    input  logic [31:0] i_width_raw,
    input  logic [31:0] i_height_raw,
    input  logic [31:0] i_planes_bpp,
    input  logic [31:0] i_compression,
    output logic [31:0] o_height_abs,
    output t_hdr_chk    o_chk
);

    logic fmt_bad;
    logic size_bad;

    // two's complement magnitude; the most negative value stays large
    assign o_height_abs = i_height_raw[31] ? (32'd0 - i_height_raw) : i_height_raw;

    assign fmt_bad  = (i_planes_bpp != PLANES_BPP_OK) || (i_compression != 32'd0);
    assign size_bad = (i_width_raw > 32'(MAX_WIDTH)) || (o_height_abs > 32'(MAX_HEIGHT));

    always_comb begin
        o_chk.err  = 1'b1;
        o_chk.code = ERR_SIGNATURE;
        if (!i_sig_ok) begin
            o_chk.code = ERR_SIGNATURE;
        end else if (fmt_bad) begin
            o_chk.code = ERR_FORMAT;
        end else if (i_offset < HDR_LEN) begin
            o_chk.code = ERR_OFFSET;
        end else if (size_bad) begin
            o_chk.code = ERR_SIZE;
        end else begin
            o_chk.err = 1'b0;
        end
        o_chk.top_first = i_height_raw[31];
        o_chk.zero_size = (i_width_raw == 32'd0) || (o_height_abs == 32'd0);
        o_chk.no_skip   = (i_offset == HDR_LEN);
    end

endmodule

// File: design/bmp24_parse_core.sv
// parse state machine: header capture, offset skip, pixel assembly
// depends on bmp24_pkg and bmp24_hdr_check

module bmp24_parse_core
    import bmp24_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_req  i_req,
    output logic     o_res_valid,
    output t_out_req o_res
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    t_phase          r_phase, n_phase;
    logic [31:0]     r_position, n_position;
    logic [31:0]     r_offset, n_offset;
    logic [31:0]     r_width_raw, n_width_raw;
    logic [31:0]     r_height_raw, n_height_raw;
    logic [31:0]     r_planes_bpp, n_planes_bpp;
    logic [31:0]     r_compression, n_compression;
    logic            r_sig_ok, n_sig_ok;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [1:0]      r_bip, n_bip;
    logic [1:0]      r_pad, n_pad;
    logic [15:0]     r_hold_bg, n_hold_bg;
    logic            r_top_first, n_top_first;
    logic [CW-1:0]   r_width, n_width;
    logic [RW-1:0]   r_height, n_height;

    t_phase          cur_phase;
    logic [31:0]     cur_pos;
    logic [7:0]      b;
    logic [31:0]     height_abs;
    t_hdr_chk        chk;
    logic [32:0]     skip_next;
    logic            end_row;
    logic            end_img;
    logic [RW-1:0]   dst_row;
    logic [31:0]     col_ext;
    logic [31:0]     row_ext;
    logic [31:0]     width_ext;

    function automatic logic [31:0] set_lane(input logic [31:0] old, input logic [31:0] rel,
                                             input logic [7:0] v);
        logic [31:0] res;
        res = old;
        res[8 * rel[1:0] +: 8] = v;
        return res;
    endfunction

    function automatic logic in_field(input logic [31:0] pos, input logic [31:0] base);
        return (pos >= base) && (pos <= base + HDR_FIELD_LAST);
    endfunction

    bmp24_hdr_check #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_hdr_check (
        .i_sig_ok      (r_sig_ok),
        .i_offset      (r_offset),
        .i_width_raw   (r_width_raw),
        .i_height_raw  (r_height_raw),
        .i_planes_bpp  (r_planes_bpp),
        .i_compression (r_compression),
        .o_height_abs  (height_abs),
        .o_chk         (chk)
    );

    // a first byte restarts the parse from the header
    assign cur_phase = i_req.first_byte ? PH_HEADER : r_phase;
    assign cur_pos   = i_req.first_byte ? 32'd0 : r_position;
    assign b         = i_req.data_byte;
    assign skip_next = {1'b0, r_position} + 33'd1;

    assign end_row   = ({1'b0, r_col} + 1'b1) == {1'b0, r_width};
    assign end_img   = end_row && (({1'b0, r_row} + 1'b1) == {1'b0, r_height});
    assign dst_row   = r_top_first ? r_row : (r_height - RW'(1) - r_row);
    assign col_ext   = 32'(r_col);
    assign row_ext   = 32'(dst_row);
    assign width_ext = 32'(r_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_position  <= '0;
            r_sig_ok    <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_bip       <= '0;
            r_pad       <= '0;
            r_top_first <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_position  <= n_position;
            r_sig_ok    <= n_sig_ok;
            r_col       <= n_col;
            r_row       <= n_row;
            r_bip       <= n_bip;
            r_pad       <= n_pad;
            r_top_first <= n_top_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset      <= n_offset;
        r_width_raw   <= n_width_raw;
        r_height_raw  <= n_height_raw;
        r_planes_bpp  <= n_planes_bpp;
        r_compression <= n_compression;
        r_hold_bg     <= n_hold_bg;
        r_width       <= n_width;
        r_height      <= n_height;
    end

    always_comb begin
        n_phase       = r_phase;
        n_position    = r_position;
        n_offset      = r_offset;
        n_width_raw   = r_width_raw;
        n_height_raw  = r_height_raw;
        n_planes_bpp  = r_planes_bpp;
        n_compression = r_compression;
        n_sig_ok      = r_sig_ok;
        n_col         = r_col;
        n_row         = r_row;
        n_bip         = r_bip;
        n_pad         = r_pad;
        n_hold_bg     = r_hold_bg;
        n_top_first   = r_top_first;
        n_width       = r_width;
        n_height      = r_height;
        o_res_valid   = 1'b0;
        o_res         = '0;

        if (i_fire) begin
            n_phase = cur_phase;
            case (cur_phase)
                PH_HEADER: begin
                    if (cur_pos == HDR_SIG0_POS) begin
                        n_sig_ok = (b == SIG_B);
                    end else if (cur_pos == HDR_SIG1_POS) begin
                        n_sig_ok = r_sig_ok && (b == SIG_M);
                    end else if (in_field(cur_pos, HDR_OFS_POS)) begin
                        n_offset = set_lane(r_offset, cur_pos - HDR_OFS_POS, b);
                    end else if (in_field(cur_pos, HDR_WIDTH_POS)) begin
                        n_width_raw = set_lane(r_width_raw, cur_pos - HDR_WIDTH_POS, b);
                    end else if (in_field(cur_pos, HDR_HEIGHT_POS)) begin
                        n_height_raw = set_lane(r_height_raw, cur_pos - HDR_HEIGHT_POS, b);
                    end else if (in_field(cur_pos, HDR_PB_POS)) begin
                        n_planes_bpp = set_lane(r_planes_bpp, cur_pos - HDR_PB_POS, b);
                    end else if (in_field(cur_pos, HDR_COMP_POS)) begin
                        n_compression = set_lane(r_compression, cur_pos - HDR_COMP_POS, b);
                    end

                    if (cur_pos != HDR_LAST_POS) begin
                        n_position = cur_pos + 32'd1;
                    end else if (chk.err) begin
                        n_position       = cur_pos;
                        n_phase          = PH_IDLE;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = chk.code;
                    end else begin
                        n_top_first = chk.top_first;
                        n_col       = '0;
                        n_row       = '0;
                        n_bip       = '0;
                        n_pad       = '0;
                        n_position  = HDR_LEN;
                        // size already checked, so the narrow copies lose nothing
                        n_width     = r_width_raw[CW-1:0];
                        n_height    = height_abs[RW-1:0];
                        if (chk.zero_size) begin
                            n_phase = PH_IDLE;
                        end else if (chk.no_skip) begin
                            n_phase = PH_PIXELS;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (skip_next >= {1'b0, r_offset}) begin
                        n_phase = PH_PIXELS;
                    end else begin
                        n_position = skip_next[31:0];
                    end
                end
                PH_PIXELS: begin
                    if (r_pad != 2'd0) begin
                        n_pad = r_pad - 2'd1;
                    end else if (r_bip == 2'd0) begin
                        n_hold_bg = {8'h00, b};
                        n_bip     = 2'd1;
                    end else if (r_bip == 2'd1) begin
                        n_hold_bg = {b, r_hold_bg[7:0]};
                        n_bip     = 2'd2;
                    end else begin
                        n_bip            = 2'd0;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_PIXEL;
                        o_res.error_code = ERR_SIGNATURE;
                        o_res.red        = b;
                        o_res.green      = r_hold_bg[15:8];
                        o_res.blue       = r_hold_bg[7:0];
                        o_res.col        = col_ext[11:0];
                        o_res.row        = row_ext[11:0];
                        o_res.last       = end_img;
                        if (end_img) begin
                            n_phase = PH_IDLE;
                        end else if (end_row) begin
                            n_col = '0;
                            n_row = r_row + RW'(1);
                            n_pad = width_ext[1:0];
                        end else begin
                            n_col = r_col + CW'(1);
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/bmp24_out_reg.sv
// result register with valid/stall handshake toward the sink
// depends on bmp24_pkg

module bmp24_out_reg
    import bmp24_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  logic     i_res_valid,
    input  t_out_req i_res,
    output logic     o_ready,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    logic     r_valid, n_valid;
    t_out_req r_req;

    assign o_ready     = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_req   = r_req;

    always_comb begin
        n_valid = r_valid && i_out_stall;
        if (i_fire) begin
            n_valid = i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_res_valid) begin
            r_req <= i_res;
        end
    end

endmodule

// File: design/bmp24_stream_parser_unit.sv
// top level of the 24-bit bmp stream parser: input register, parse core, result register
// depends on bmp24_pkg, bmp24_parse_core, bmp24_out_reg
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_in_req  (data_byte, first_byte)
//  out     | source    | o_out_valid / i_out_stall | o_out_req (kind, error_code, rgb,
//          |           |                           |            col, row, last)
//
// one byte per clock sustained while the output does not stall; a byte is held in the
// input register, and its result, if any, enters the result register as it is processed
// all per-byte work is counter updates, byte captures and 32-bit compares in the core
// synchronous active-low reset puts the parser in the header phase at byte zero
// a stall on the output holds the result register; the input register then fills
// and the input side stalls, with no request lost or repeated

module bmp24_stream_parser_unit
    import bmp24_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    // input register
    logic     r_in_valid, n_in_valid;
    t_in_req  r_in_req;

    logic     fire;
    logic     out_ready;
    logic     res_valid;
    t_out_req res;

    // the held byte is processed as soon as the result register can take its result
    assign fire       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !fire;

    always_comb begin
        n_in_valid = r_in_valid && !fire;
        if (i_in_valid && !o_in_stall) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // payload register, loaded only on an accepted request
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_req <= i_in_req;
        end
    end

    // header capture, skip and pixel assembly
    bmp24_parse_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parse_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_req       (r_in_req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register toward the sink
    bmp24_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule
